>>> design/bamf_pkg.sv
// Package for the maximum flow block: payload structs, state codes and constants.
package bamf_pkg;

  // Widths fixed by the payload fields.
  localparam int unsigned NodeFieldW = 7;
  localparam int unsigned CapFieldW  = 24;
  localparam int unsigned EntryW     = 33;
  localparam int unsigned FlowW      = 38;
  localparam logic [31:0] EntrySat   = 32'hFFFF_FFFF;

  // One input beat.
  typedef struct packed {
    logic [NodeFieldW-1:0] from_node;
    logic [NodeFieldW-1:0] to_node;
    logic [CapFieldW-1:0]  capacity;
    logic                  last_edge;
  } bamf_in_t;

  // One result beat.
  typedef struct packed {
    logic [FlowW-1:0] max_flow;
    logic             edge_dropped;
  } bamf_out_t;

  // Sequencer states.
  typedef enum logic [4:0] {
    ST_CLEAR,      // sweep the matrix to zero
    ST_IDLE,
    ST_LOAD_RD,    // read entry for an incoming edge
    ST_LOAD_WR,    // add and write back
    ST_BFS_INIT,   // clear visited marks
    ST_BFS_POP,    // read queue head
    ST_BFS_POPW,   // queue data returns
    ST_BFS_SCAN,   // issue read of cur,nb
    ST_BFS_CHK,    // examine entry
    ST_PATH_RD,    // fetch predecessor of the sink
    ST_NECK_RD,    // read entry pred->v
    ST_NECK_CHK,
    ST_UPD_FRD,    // read forward entry
    ST_UPD_FWR,    // write forward entry
    ST_UPD_RRD,    // read reverse entry
    ST_UPD_RWR,    // write reverse entry
    ST_DONE        // emit result, then clear
  } bamf_state_t;

endpackage

>>> design/bamf_ram.sv
// Generic single-port RAM with a registered read.
module bamf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read-first port access: a write returns the old entry; read data is registered and lands in the next cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> design/bfs_augmenting_max_flow.sv
// Top level of the maximum flow engine (shortest augmenting paths).
//
// Usage: edges arrive on the in_ channel, one beat accepted when start is high
// and busy is low. Each in-range beat adds its capacity to one entry of a
// residual matrix held in a single-port RAM by a read and a write back; a
// dropped edge only sets the drop flag. The beat marked last_edge starts the
// search. Each breadth-first search clears the visited marks, then reads each
// dequeued node from the queue RAM and reads and checks each matrix entry
// scanned. Each augmenting path fetches the sink's predecessor, reads each hop
// for the bottleneck and reads and writes both entries of each hop for the
// update. The number of paths depends on the graph, so the run time is data
// dependent and set by the single matrix port. The result comes in the cycle
// after the final search. The result appears on out_ with out_valid high for
// exactly one cycle; the receiver cannot stall it. After each result, and
// after reset, the matrix is swept to zero at one entry per cycle (4096
// entries at 64 nodes) while busy stays high. The cfg_ APB port holds
// node_count at address 0; write only when idle.
module bfs_augmenting_max_flow
  import bamf_pkg::*;
#(
  parameter int unsigned NODES          = 64,
  parameter int unsigned CAPACITY_WIDTH = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  bamf_in_t    in_data,
  output logic        out_valid,
  output bamf_out_t   out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int unsigned IW = $clog2(NODES);
  localparam int unsigned AW = 2 * IW;
  localparam int unsigned CW = IW + 1;
  localparam int unsigned ND = 1 << AW;
  localparam logic [EntryW-1:0] EntryAll = {EntryW{1'b1}};
  localparam logic [CapFieldW-1:0] CapMask =
    CapFieldW'((64'd1 << CAPACITY_WIDTH) - 64'd1);

  // Configuration register.
  logic [NodeFieldW-1:0] node_count_r;
  logic cfg_wr;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr == 2'd0);
  assign cfg_pready = 1'b1;
  assign cfg_prdata = {{(32-NodeFieldW){1'b0}}, node_count_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NodeFieldW'(64);
    end else if (cfg_wr) begin
      node_count_r <= cfg_pwdata[NodeFieldW-1:0];
    end
  end

  // Effective node count clipped to 2..NODES, as a sink index.
  logic [CW-1:0] sink_idx;
  always_comb begin
    priority if (node_count_r < NodeFieldW'(2)) begin
      sink_idx = CW'(1);
    end else if (32'(node_count_r) > NODES) begin
      sink_idx = CW'(NODES - 1);
    end else begin
      sink_idx = CW'(node_count_r - NodeFieldW'(1));
    end
  end

  // Matrix RAM.
  logic              m_we;
  logic [AW-1:0]     m_addr;
  logic [EntryW-1:0] m_wdata, m_rdata;
  bamf_ram #(.WIDTH(EntryW), .DEPTH(ND)) u_matrix (
    .clk(clk), .we(m_we), .addr(m_addr), .wdata(m_wdata), .rdata(m_rdata)
  );

  // Search state.
  logic [NODES-1:0]  visited_r, visited_nxt;
  logic [IW-1:0]     qhead_r, qhead_nxt, qtail_r, qtail_nxt;
  logic [IW-1:0]     cur_r, cur_nxt, v_r, v_nxt;
  logic [CW-1:0]     nb_r, nb_nxt;
  logic [AW:0]       clr_r, clr_nxt;
  logic [EntryW-1:0] neck_r, neck_nxt;
  logic [FlowW-1:0]  flow_r, flow_nxt;
  logic              drop_r, drop_nxt;
  logic [AW-1:0]     eaddr_r, eaddr_nxt;
  logic [CapFieldW-1:0] cap_r, cap_nxt;
  logic              last_r, last_nxt;
  logic              q_push, p_wr;
  logic [IW-1:0]     q_addr, q_wdata, q_rdata;
  logic [IW-1:0]     p_addr, p_rdata;
  bamf_state_t       state_r, state_nxt;

  // Search queue and predecessor RAMs.
  bamf_ram #(.WIDTH(IW), .DEPTH(NODES)) u_queue (
    .clk(clk), .we(q_push), .addr(q_addr), .wdata(q_wdata), .rdata(q_rdata)
  );
  bamf_ram #(.WIDTH(IW), .DEPTH(NODES)) u_pred (
    .clk(clk), .we(p_wr), .addr(p_addr), .wdata(cur_r), .rdata(p_rdata)
  );

  logic accept;
  assign accept = start && !busy;
  assign busy   = (state_r != ST_IDLE);

  // Edge range check against the effective node count.
  logic in_ok;
  assign in_ok = (in_data.from_node != '0) && (in_data.to_node != '0)
              && (CW'(in_data.from_node - 1'b1) <= sink_idx)
              && (in_data.to_node - 1'b1 <= NodeFieldW'(sink_idx))
              && (in_data.from_node - 1'b1 <= NodeFieldW'(sink_idx));

  // The predecessor RAM is addressed with the next v, so its data is pred[v_r].
  logic [IW-1:0] pv;
  assign pv = p_rdata;
  logic [EntryW:0] sat_sum;
  assign sat_sum = {1'b0, m_rdata} + (EntryW+1)'(cap_r & CapMask);

  // Sequencer: next state, RAM ports and search bookkeeping.
  always_comb begin
    state_nxt = state_r;
    visited_nxt = visited_r; qhead_nxt = qhead_r; qtail_nxt = qtail_r;
    cur_nxt = cur_r; v_nxt = v_r; nb_nxt = nb_r; clr_nxt = clr_r;
    neck_nxt = neck_r; flow_nxt = flow_r; drop_nxt = drop_r;
    eaddr_nxt = eaddr_r; cap_nxt = cap_r; last_nxt = last_r;
    m_we = 1'b0; m_addr = eaddr_r; m_wdata = '0;
    q_push = 1'b0; q_addr = qhead_r; q_wdata = '0;
    p_wr = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        m_we = 1'b1; m_addr = clr_r[AW-1:0];
        clr_nxt = clr_r + 1'b1;
        if (clr_r == (AW+1)'(ND - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          cap_nxt = in_data.capacity; last_nxt = in_data.last_edge;
          eaddr_nxt = {IW'(in_data.from_node - 1'b1), IW'(in_data.to_node - 1'b1)};
          if (in_ok) begin
            state_nxt = ST_LOAD_RD;
          end else begin
            drop_nxt = 1'b1;
            state_nxt = in_data.last_edge ? ST_BFS_INIT : ST_IDLE;
          end
          flow_nxt = '0;
        end
      end
      ST_LOAD_RD: state_nxt = ST_LOAD_WR;
      ST_LOAD_WR: begin
        m_we = 1'b1;
        m_wdata = (sat_sum > (EntryW+1)'(EntrySat)) ? {1'b0, EntrySat} : sat_sum[EntryW-1:0];
        state_nxt = last_r ? ST_BFS_INIT : ST_IDLE;
      end
      ST_BFS_INIT: begin
        visited_nxt = '0; visited_nxt[0] = 1'b1;
        qhead_nxt = '0; qtail_nxt = IW'(1);
        q_push = 1'b1; q_addr = '0; q_wdata = '0;
        state_nxt = ST_BFS_POP;
      end
      ST_BFS_POP: begin
        if (qhead_r == qtail_r) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_BFS_POPW;
        end
      end
      ST_BFS_POPW: begin
        cur_nxt = q_rdata; nb_nxt = '0;
        state_nxt = ST_BFS_SCAN;
      end
      ST_BFS_SCAN: begin
        m_addr = {cur_r, nb_r[IW-1:0]};
        state_nxt = ST_BFS_CHK;
      end
      ST_BFS_CHK: begin
        if (m_rdata != '0 && !visited_r[nb_r[IW-1:0]]) begin
          visited_nxt[nb_r[IW-1:0]] = 1'b1;
          q_push = 1'b1; q_addr = qtail_r; q_wdata = nb_r[IW-1:0];
          p_wr = 1'b1;
          qtail_nxt = qtail_r + 1'b1;
        end
        if (m_rdata != '0 && !visited_r[nb_r[IW-1:0]] && nb_r == sink_idx) begin
          v_nxt = sink_idx[IW-1:0]; neck_nxt = EntryAll;
          state_nxt = ST_PATH_RD;
        end else if (nb_r == sink_idx) begin
          qhead_nxt = qhead_r + 1'b1;
          state_nxt = ST_BFS_POP;
        end else begin
          nb_nxt = nb_r + 1'b1;
          state_nxt = ST_BFS_SCAN;
        end
      end
      ST_PATH_RD: state_nxt = ST_NECK_RD;
      ST_NECK_RD: begin
        m_addr = {pv, v_r};
        state_nxt = ST_NECK_CHK;
      end
      ST_NECK_CHK: begin
        if (m_rdata < neck_r) neck_nxt = m_rdata;
        v_nxt = pv;
        if (pv == '0) begin
          v_nxt = sink_idx[IW-1:0];
          state_nxt = ST_UPD_FRD;
        end else begin
          state_nxt = ST_NECK_RD;
        end
      end
      ST_UPD_FRD: begin
        m_addr = {pv, v_r}; state_nxt = ST_UPD_FWR;
      end
      ST_UPD_FWR: begin
        m_addr = {pv, v_r}; m_we = 1'b1; m_wdata = m_rdata - neck_r;
        state_nxt = ST_UPD_RRD;
      end
      ST_UPD_RRD: begin
        m_addr = {v_r, pv}; state_nxt = ST_UPD_RWR;
      end
      ST_UPD_RWR: begin
        m_addr = {v_r, pv}; m_we = 1'b1; m_wdata = m_rdata + neck_r;
        v_nxt = pv;
        if (pv == '0) begin
          flow_nxt = flow_r + {{(FlowW-EntryW){1'b0}}, neck_r};
          state_nxt = ST_BFS_INIT;
        end else begin
          state_nxt = ST_UPD_FRD;
        end
      end
      ST_DONE: begin
        out_valid = 1'b1;
        drop_nxt = 1'b0; clr_nxt = '0;
        state_nxt = ST_CLEAR;
      end
      default: state_nxt = ST_CLEAR;
    endcase
    // Predecessor port: write a new parent, otherwise track the next v.
    p_addr = p_wr ? nb_r[IW-1:0] : v_nxt;
  end

  assign out_data.max_flow     = flow_r;
  assign out_data.edge_dropped = drop_r;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR; clr_r <= '0; visited_r <= '0;
      qhead_r <= '0; qtail_r <= '0; flow_r <= '0; drop_r <= 1'b0;
    end else begin
      state_r <= state_nxt; clr_r <= clr_nxt; visited_r <= visited_nxt;
      qhead_r <= qhead_nxt; qtail_r <= qtail_nxt; flow_r <= flow_nxt; drop_r <= drop_nxt;
    end
  end

  // Payload registers: working values of the search and the pending edge.
  always_ff @(posedge clk) begin
    cur_r <= cur_nxt; v_r <= v_nxt; nb_r <= nb_nxt; neck_r <= neck_nxt;
    eaddr_r <= eaddr_nxt; cap_r <= cap_nxt; last_r <= last_nxt;
  end

  // A result only leaves from the done state and is followed by the clear sweep.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> state_r == ST_CLEAR) else $error("result not followed by clear");
  // The source is always marked once a search runs.
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_BFS_POP |-> visited_r[0]) else $error("source not visited");
  // No beat is accepted while the sequencer works.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> busy) else $error("busy low while working");

endmodule

>>> sim/bfs_augmenting_max_flow_checker.sv
// Flow checker: watches the edge, config and result channels, predicts and compares.
`timescale 1ns / 100ps
module bfs_augmenting_max_flow_checker
  import bamf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  bamf_in_t    in_data,
  input  logic        out_valid,
  input  bamf_out_t   out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          fail_count,
  output int          pending,
  output int          graphs_seen
);
  localparam int Nodes = 64;
  localparam logic [1:0] AddrNodeCount = 2'd0;

  logic [6:0]  node_reg;
  logic [32:0] cap_mat [Nodes][Nodes];
  logic        drop_seen;
  bamf_out_t   flow_q[$];

  // Effective node count after clamping.
  function automatic int clamp_nodes(logic [6:0] v);
    if (v < 2) return 2;
    if (v > Nodes) return Nodes;
    return int'(v);
  endfunction

  // Edmonds-Karp over the shadow matrix; returns the total flow.
  function automatic logic [37:0] solve_flow(int sink);
    bit          seen [Nodes];
    int          par [Nodes];
    int          fifo [$];
    logic [37:0] total;
    logic [32:0] neck;
    int          cur, v, p;
    bit          found;
    total = '0;
    forever begin
      foreach (seen[i]) seen[i] = 0;
      fifo.delete();
      fifo.push_back(0);
      seen[0] = 1;
      found = 0;
      while (fifo.size() != 0 && !found) begin
        cur = fifo.pop_front();
        for (int nb = 0; nb <= sink && !found; nb++) begin
          if (cap_mat[cur][nb] != 0 && !seen[nb]) begin
            seen[nb] = 1;
            par[nb] = cur;
            fifo.push_back(nb);
            if (nb == sink) found = 1;
          end
        end
      end
      if (!found) break;
      neck = '1;
      for (v = sink; v != 0; v = par[v]) begin
        p = par[v];
        if (cap_mat[p][v] < neck) neck = cap_mat[p][v];
      end
      for (v = sink; v != 0; v = par[v]) begin
        p = par[v];
        cap_mat[p][v] = cap_mat[p][v] - neck;
        cap_mat[v][p] = cap_mat[v][p] + neck;
      end
      total = total + 38'(neck);
    end
    return total;
  endfunction

  // Edge loads, register writes and result comparison on each edge.
  always @(posedge clk) begin
    int        nc, f, t;
    int        errs;
    logic [33:0] sum;
    bamf_out_t exp_r;
    errs = 0;
    if (!rst_n) begin
      node_reg <= 7'd64;
      drop_seen = 0;
      foreach (cap_mat[i, j]) cap_mat[i][j] = '0;
      flow_q.delete();
      fail_count <= 0;
      graphs_seen <= 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr == AddrNodeCount)
        node_reg <= cfg_pwdata[6:0];
      if (out_valid) begin
        if (flow_q.size() == 0) begin
          $error("result beat with no graph pending");
          errs++;
        end else begin
          exp_r = flow_q.pop_front();
          graphs_seen <= graphs_seen + 1;
          if (out_data.max_flow !== exp_r.max_flow) begin
            $error("max_flow: expected %0d, got %0d", exp_r.max_flow, out_data.max_flow);
            errs++;
          end
          if (out_data.edge_dropped !== exp_r.edge_dropped) begin
            $error("edge_dropped: expected %0b, got %0b", exp_r.edge_dropped,
                   out_data.edge_dropped);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count <= fail_count + errs;
      if (start && !busy) begin
        nc = clamp_nodes(node_reg);
        f = int'(in_data.from_node);
        t = int'(in_data.to_node);
        if (f >= 1 && f <= nc && t >= 1 && t <= nc) begin
          sum = 34'(cap_mat[f-1][t-1]) + 34'(in_data.capacity);
          cap_mat[f-1][t-1] = (sum > 34'hFFFF_FFFF) ? 33'hFFFF_FFFF : sum[32:0];
        end else begin
          drop_seen = 1;
        end
        if (in_data.last_edge) begin
          exp_r.max_flow = solve_flow(nc - 1);
          exp_r.edge_dropped = drop_seen;
          flow_q.push_back(exp_r);
          drop_seen = 0;
          foreach (cap_mat[i, j]) cap_mat[i][j] = '0;
        end
      end
    end
  end

  assign pending = flow_q.size();
endmodule

>>> sim/bfs_augmenting_max_flow_tb.sv
// Testbench top: drives graphs and node_count settings into the flow block.
`timescale 1ns / 100ps
module bfs_augmenting_max_flow_tb;
  import bamf_pkg::*;

  localparam logic [1:0] AddrNodeCount = 2'd0;

  logic        clk, rst_n, start, busy, out_valid;
  bamf_in_t    in_data;
  bamf_out_t   out_data;
  logic        cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [1:0]  cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  int          fail_count, pending, graphs_seen;
  int          idle_pct;
  int          beats_sent;
  logic [6:0]  cur_nodes;

  bfs_augmenting_max_flow dut (.*);

  bfs_augmenting_max_flow_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // APB write of node_count: a setup phase, then an access phase.
  task automatic write_nodes(input logic [31:0] val);
    @(posedge clk);
    cfg_psel <= 1; cfg_penable <= 0; cfg_pwrite <= 1;
    cfg_paddr <= AddrNodeCount; cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    cur_nodes = val[6:0];
  endtask

  // Send one edge beat, with random idle gaps before it. Start stays high
  // after the accepting edge until the next beat or an idle cycle replaces it.
  task automatic send_edge(input logic [6:0] f, input logic [6:0] t,
                           input logic [23:0] c, input logic lst);
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    in_data <= '{from_node: f, to_node: t, capacity: c, last_edge: lst};
    @(posedge clk);
    while (busy) @(posedge clk);
    beats_sent++;
  endtask

  // Wait until every graph has returned its flow and the block is idle.
  task automatic drain;
    start <= 0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Random graph: mostly in-range edges among nodes 1 to the clamped node count.
  task automatic random_graph(input int n_edges);
    int nc;
    logic [6:0] f, t;
    logic [23:0] c;
    nc = (cur_nodes < 2) ? 2 : (cur_nodes > 64 ? 64 : cur_nodes);
    for (int k = 0; k < n_edges; k++) begin
      if ($urandom_range(19) == 0) begin
        f = 7'($urandom); t = 7'($urandom);
      end else begin
        f = 7'($urandom_range(nc, 1)); t = 7'($urandom_range(nc, 1));
      end
      case ($urandom_range(3))
        0: c = 24'($urandom);
        1: c = 24'hFF_FFFF;
        default: c = 24'($urandom_range(255));
      endcase
      send_edge(f, t, c, k == n_edges - 1);
    end
  endtask

  initial begin
    start = 0; in_data = '0; rst_n = 0; beats_sent = 0; idle_pct = 0;
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0; cfg_paddr = '0; cfg_pwdata = '0;
    cur_nodes = 7'd64;
    repeat (5) @(posedge clk);
    rst_n <= 1;

    // Directed: empty graph, full range, saturation, self loop, dropped edges.
    write_nodes(2);
    send_edge(1, 1, 0, 1);
    send_edge(1, 2, 24'hFF_FFFF, 0);
    repeat (260) send_edge(1, 2, 24'hFF_FFFF, 0);
    send_edge(1, 2, 24'hFF_FFFF, 1);
    send_edge(2, 2, 5, 0);
    send_edge(0, 2, 9, 0);
    send_edge(1, 2, 7, 1);
    send_edge(3, 1, 4, 1);
    drain();
    write_nodes(64);
    send_edge(1, 64, 24'h55_AAAA, 0);
    send_edge(64, 1, 24'hAA_5555, 0);
    send_edge(127, 127, 1, 0);
    send_edge(1, 65, 1, 1);
    drain();
    // Node count below and above the legal range clamps.
    write_nodes(0);
    send_edge(1, 2, 3, 1);
    drain();
    write_nodes(127);
    send_edge(1, 64, 11, 1);
    drain();
    // Node count changed mid-graph: high nodes are ignored.
    write_nodes(8);
    send_edge(1, 4, 10, 0);
    send_edge(4, 8, 6, 0);
    drain();
    write_nodes(4);
    send_edge(1, 4, 2, 1);
    drain();

    // Random phases over several node counts and idle profiles.
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 23 : (ph == 1 ? 48 : 0);
      for (int g = 0; g < 10; g++) begin
        if (g % 4 == 0) begin
          drain();
          case ($urandom_range(3))
            0: write_nodes(2);
            1: write_nodes(64);
            default: write_nodes($urandom_range(12, 3));
          endcase
        end
        random_graph($urandom_range(18, 1));
        if (g == 5) drain();
      end
    end
    drain();
    $display("Sent %0d edge beats; %0d graphs solved over node counts 2..64.",
             beats_sent, graphs_seen);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("FAIL");
    $finish;
  end
endmodule
